@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define B64D_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication, disabled while reset is asserted.
`define B64D_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ hdl/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the character decode table of the base64 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_LEN   = 2'd1;
	localparam logic [1:0] ST_STRAY_PAD = 2'd2;
	localparam logic [1:0] ST_BAD_CHAR  = 2'd3;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PAD   = 8'h3D;

	localparam logic [5:0] OFS_LOWER = 6'd26;
	localparam logic [5:0] OFS_DIGIT = 6'd52;
	localparam logic [5:0] VAL_PLUS  = 6'd62;
	localparam logic [5:0] VAL_SLASH = 6'd63;

	// One decoded group or one end-of-string status for the back end.
	typedef struct packed {
		logic        is_status;
		logic [1:0]  status;
		logic [23:0] word;
		logic [1:0]  count;   // data bytes in word, 1..3
	} job_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] value;
	} sextet_t;

	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t r;
		r.ok    = 1'b1;
		r.value = 6'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r.value = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r.value = 6'(c - 8'h61) + OFS_LOWER;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r.value = 6'(c - 8'h30) + OFS_DIGIT;
		end else if (c == CH_PLUS) begin
			r.value = VAL_PLUS;
		end else if (c == CH_SLASH) begin
			r.value = VAL_SLASH;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hdl/b64d_front.sv @@
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, tracks group and error state, and queues one job per
// completed error-free group and one per end-of-string item.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic           kind,
	input  wire logic [7:0]     symbol,
	input  wire logic           q_full,
	output logic                q_push,
	output b64d_pkg::job_t      q_job
);

	logic [17:0] bits_q;
	logic [1:0]  pos_q;
	logic [1:0]  pad_q;
	logic        padded_done_q;
	logic        stray_q;
	logic        bad_q;

	b64d_pkg::sextet_t dec;
	logic [5:0] v;
	logic [1:0] pad_n;
	logic       stray_n;
	logic       bad_n;
	logic [1:0] st;
	logic       accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		dec     = b64d_pkg::sextet_of(symbol);
		v       = dec.value;
		pad_n   = pad_q;
		stray_n = stray_q | padded_done_q;
		bad_n   = bad_q;
		if (symbol == b64d_pkg::CH_PAD) begin
			v = 6'd0;
			if (pos_q < 2'd2) stray_n = 1'b1;
			else pad_n = pad_q + 2'd1;
		end else begin
			if (!dec.ok) bad_n = 1'b1;
			if (pad_q != 2'd0) stray_n = 1'b1;
		end

		if (pos_q != 2'd0) st = b64d_pkg::ST_BAD_LEN;
		else if (stray_q) st = b64d_pkg::ST_STRAY_PAD;
		else if (bad_q) st = b64d_pkg::ST_BAD_CHAR;
		else st = b64d_pkg::ST_OK;

		q_job = '0;
		q_push = 1'b0;
		if (kind == b64d_pkg::KIND_END) begin
			q_job.is_status = 1'b1;
			q_job.status    = st;
			q_job.count     = 2'd1;
			q_push          = accept;
		end else begin
			q_job.word  = {bits_q, v};
			q_job.count = (pad_n <= 2'd2) ? 2'(2'd3 - pad_n) : 2'd1;
			q_push      = accept && pos_q == 2'd3 && !stray_n && !bad_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q        <= '0;
			pos_q         <= '0;
			pad_q         <= '0;
			padded_done_q <= 1'b0;
			stray_q       <= 1'b0;
			bad_q         <= 1'b0;
		end else if (accept) begin
			if (kind == b64d_pkg::KIND_END) begin
				bits_q        <= '0;
				pos_q         <= '0;
				pad_q         <= '0;
				padded_done_q <= 1'b0;
				stray_q       <= 1'b0;
				bad_q         <= 1'b0;
			end else begin
				stray_q <= stray_n;
				bad_q   <= bad_n;
				if (pos_q != 2'd3) begin
					bits_q <= {bits_q[11:0], v};
					pos_q  <= pos_q + 2'd1;
					pad_q  <= pad_n;
				end else begin
					bits_q <= '0;
					pos_q  <= '0;
					pad_q  <= '0;
					if (pad_n != 2'd0) padded_done_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/b64d_queue.sv @@
// ----------------------------------------------------------------------------
// b64d_queue
// Small job FIFO between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module b64d_queue #(
	parameter int Depth = b64d_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire b64d_pkg::job_t push_job,
	input  wire logic           pop,
	output logic                full,
	output logic                empty,
	output b64d_pkg::job_t      head
);

	localparam int AW = $clog2(Depth);
	localparam int CW = $clog2(Depth + 1);

	b64d_pkg::job_t mem_q [Depth];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full    = count_q == CW'(Depth);
	assign empty   = count_q == '0;
	assign head    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
			if (do_pop) rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`B64D_ASSERT_IMPL(a_no_push_full, clk, arst_n, push, !full, "push into full queue")
	`B64D_ASSERT(a_count_range, clk, arst_n, count_q <= CW'(Depth), "queue count overflow")

endmodule

`default_nettype wire

@@ hdl/b64d_back.sv @@
// ----------------------------------------------------------------------------
// b64d_back
// Takes jobs from the queue and emits their bytes or status, one result per
// cycle while jobs wait and out_ready is high, via a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module b64d_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	input  wire b64d_pkg::job_t q_head,
	output logic                q_pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic                is_status,
	output logic [7:0]          data_byte,
	output logic [1:0]          status,
	output logic                last_of_run
);

	logic       valid_q;
	logic [1:0] idx_q;
	logic       is_status_q;
	logic [7:0] byte_q;
	logic [1:0] status_q;
	logic       last_q;

	logic       advance;
	logic       last_n;
	logic [7:0] byte_n;

	assign out_valid   = valid_q;
	assign is_status   = is_status_q;
	assign data_byte   = byte_q;
	assign status      = status_q;
	assign last_of_run = last_q;

	assign advance = !q_empty && (!valid_q || out_ready);
	assign last_n  = q_head.is_status || (idx_q + 2'd1 == q_head.count);
	assign q_pop   = advance && last_n;

	always_comb begin
		case (idx_q)
			2'd0:    byte_n = q_head.word[23:16];
			2'd1:    byte_n = q_head.word[15:8];
			default: byte_n = q_head.word[7:0];
		endcase
		if (q_head.is_status) byte_n = 8'd0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			is_status_q <= q_head.is_status;
			byte_q      <= byte_n;
			status_q    <= q_head.is_status ? q_head.status : b64d_pkg::ST_OK;
			last_q      <= last_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (advance) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
			if (advance) idx_q <= last_n ? 2'd0 : idx_q + 2'd1;
		end
	end

	// Partway through a group the job must still sit at the queue head.
	`B64D_ASSERT_IMPL(a_mid_job_head, clk, arst_n, idx_q != 2'd0, !q_empty, "lost job mid-group")
	`B64D_ASSERT(a_idx_range, clk, arst_n, idx_q <= 2'd2, "byte index out of range")

endmodule

`default_nettype wire

@@ hdl/base64_decoder_checked_core.sv @@
// ----------------------------------------------------------------------------
// base64_decoder_checked_core
// Streaming base64 decoder with end-of-string error status.
// ----------------------------------------------------------------------------
// One character is accepted every cycle while the job queue has room. Each
// complete error-free group of four gives one to three data bytes, and each
// end-of-string item gives one status item. Results leave one per cycle
// while out_ready is high, from a registered output stage: each job is
// written into the job queue and its bytes then go through the output
// register in turn. The front end stalls (in_ready low) only when the job
// queue of QDepth entries is full. The back end issues one result per cycle,
// which is more than a full-rate input can produce (three bytes per four
// characters), so the queue only fills while out_ready is held low.
`default_nettype none

module base64_decoder_checked_core #(
	parameter int QDepth = b64d_pkg::QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       kind,
	input  wire logic [7:0] symbol,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            is_status,
	output logic [7:0]      data_byte,
	output logic [1:0]      status,
	output logic            last_of_run
);

	logic           q_full;
	logic           q_empty;
	logic           q_push;
	logic           q_pop;
	b64d_pkg::job_t q_job;
	b64d_pkg::job_t q_head;

	b64d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.symbol   (symbol),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (q_job)
	);

	b64d_queue #(
		.Depth (QDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.pop      (q_pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (q_head)
	);

	b64d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.is_status   (is_status),
		.data_byte   (data_byte),
		.status      (status),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire

@@ tb/sv/tb_base64_decoder_checked_core.sv @@
// ----------------------------------------------------------------------------
// tb_base64_decoder_checked_core
// Self-checking bench for the streaming base64 decoder: a queue-fed driver
// sends directed and random strings (well-formed, corrupted and noise), an
// in-bench decoder predicts the byte and status stream, and a monitor checks
// every output transaction in order under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_base64_decoder_checked_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET    = 320;
	localparam int MAX_GAP        = 6;
	localparam int HOLD_CYCLES    = 90;
	localparam int HOLD_AT_FIRST  = 30;
	localparam int HOLD_AT_SECOND = 150;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_MAX     = 10;

	typedef struct packed {
		logic       kind;
		logic [7:0] symbol;
	} text_item_t;

	typedef struct packed {
		logic       is_status;
		logic [7:0] data_byte;
		logic [1:0] status;
		logic       last_of_run;
	} decoded_t;

	typedef enum logic [1:0] {FLAW_DROP, FLAW_ANY, FLAW_PAD, FLAW_TAIL} flaw_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       kind        = b64d_pkg::KIND_CHAR;
	logic [7:0] symbol      = 8'h00;
	logic       out_ready   = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic       is_status;
	logic [7:0] data_byte;
	logic [1:0] status;
	logic       last_of_run;

	base64_decoder_checked_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.symbol     (symbol),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.is_status  (is_status),
		.data_byte  (data_byte),
		.status     (status),
		.last_of_run(last_of_run)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	text_item_t text_stream[$];
	decoded_t   decoded_due[$];
	logic [7:0] draft[$];

	// decoder state mirror
	logic [17:0] grp_bits;
	logic [1:0]  grp_pos;
	logic [1:0]  pad_seen;
	logic        pad_group_done;
	logic        stray_pad;
	logic        bad_symbol;

	int strings_done;
	int chars_done;
	int bytes_due;
	int status_hist[4];
	int results_seen;
	int holds_done;
	int failures;

	function automatic logic [7:0] base64_char(input logic [5:0] v);
		if (v < b64d_pkg::OFS_LOWER)
			return 8'("A") + 8'(v);
		else if (v < b64d_pkg::OFS_DIGIT)
			return 8'("a") + 8'(v - b64d_pkg::OFS_LOWER);
		else if (v < b64d_pkg::VAL_PLUS)
			return 8'("0") + 8'(v - b64d_pkg::OFS_DIGIT);
		else if (v == b64d_pkg::VAL_PLUS)
			return b64d_pkg::CH_PLUS;
		return b64d_pkg::CH_SLASH;
	endfunction

	// {in_alphabet, sextet}
	function automatic logic [6:0] sextet_lookup(input logic [7:0] c);
		if (c >= 8'("A") && c <= 8'("Z"))
			return {1'b1, 6'(c - 8'("A"))};
		if (c >= 8'("a") && c <= 8'("z"))
			return {1'b1, 6'(c - 8'("a")) + b64d_pkg::OFS_LOWER};
		if (c >= 8'("0") && c <= 8'("9"))
			return {1'b1, 6'(c - 8'("0")) + b64d_pkg::OFS_DIGIT};
		if (c == b64d_pkg::CH_PLUS)
			return {1'b1, b64d_pkg::VAL_PLUS};
		if (c == b64d_pkg::CH_SLASH)
			return {1'b1, b64d_pkg::VAL_SLASH};
		return 7'd0;
	endfunction

	task automatic clear_decoder();
		grp_bits       = '0;
		grp_pos        = '0;
		pad_seen       = '0;
		pad_group_done = 1'b0;
		stray_pad      = 1'b0;
		bad_symbol     = 1'b0;
	endtask

	task automatic decode_char(input logic item_kind, input logic [7:0] c);
		logic [1:0]  pos;
		logic [6:0]  lut;
		logic [5:0]  v;
		logic [23:0] word;
		int          n;
		decoded_t    r;
		pos = grp_pos;
		r   = '0;
		if (item_kind == b64d_pkg::KIND_END) begin
			r.is_status   = 1'b1;
			r.last_of_run = 1'b1;
			if (pos != 0)
				r.status = b64d_pkg::ST_BAD_LEN;
			else if (stray_pad)
				r.status = b64d_pkg::ST_STRAY_PAD;
			else if (bad_symbol)
				r.status = b64d_pkg::ST_BAD_CHAR;
			else
				r.status = b64d_pkg::ST_OK;
			decoded_due = {decoded_due, r};
			status_hist[r.status]++;
			strings_done++;
			clear_decoder();
			return;
		end
		chars_done++;
		if (pad_group_done)
			stray_pad = 1'b1;
		if (c == b64d_pkg::CH_PAD) begin
			v = '0;
			if (pos < 2)
				stray_pad = 1'b1;
			else
				pad_seen = pad_seen + 2'd1;
		end else begin
			lut = sextet_lookup(c);
			v   = lut[5:0];
			if (!lut[6])
				bad_symbol = 1'b1;
			if (pad_seen != 0)
				stray_pad = 1'b1;
		end
		if (pos < 3) begin
			grp_bits = {grp_bits[11:0], v};
			grp_pos  = pos + 2'd1;
			return;
		end
		word = {grp_bits, v};
		n    = (pad_seen <= 2) ? 3 - pad_seen : 1;
		if (pad_seen != 0)
			pad_group_done = 1'b1;
		grp_bits = '0;
		grp_pos  = '0;
		pad_seen = '0;
		// once an error is known the group is swallowed
		if (stray_pad || bad_symbol)
			return;
		for (int i = 0; i < n; i++) begin
			r.data_byte   = word[23 - 8 * i -: 8];
			r.last_of_run = (i == n - 1);
			decoded_due   = {decoded_due, r};
			bytes_due++;
		end
	endtask

	task automatic queue_draft();
		text_item_t t;
		foreach (draft[i]) begin
			t.kind      = b64d_pkg::KIND_CHAR;
			t.symbol    = draft[i];
			text_stream = {text_stream, t};
		end
		t.kind      = b64d_pkg::KIND_END;
		t.symbol    = 8'($urandom);
		text_stream = {text_stream, t};
	endtask

	task automatic draft_encoded(input int nbytes);
		logic [23:0] word;
		int          left;
		draft.delete();
		for (int i = 0; i < nbytes; i += 3) begin
			left  = nbytes - i;
			word  = 24'($urandom);
			draft = {draft, base64_char(word[23:18])};
			draft = {draft, base64_char(word[17:12])};
			draft = {draft, left >= 2 ? base64_char(word[11:6]) : b64d_pkg::CH_PAD};
			draft = {draft, left >= 3 ? base64_char(word[5:0]) : b64d_pkg::CH_PAD};
		end
	endtask

	task automatic corrupt_draft();
		flaw_t flaw;
		int    at;
		flaw = flaw_t'(2'($urandom_range(0, 3)));
		if (draft.size() == 0 || flaw == FLAW_TAIL) begin
			// a further group, stray if the string already ended padded
			repeat (4) draft = {draft, base64_char(6'($urandom))};
			return;
		end
		at = $urandom_range(0, draft.size() - 1);
		case (flaw)
			FLAW_DROP: draft.delete(at);
			FLAW_ANY:  draft[at] = 8'($urandom_range(0, 255));
			default:   draft[at] = b64d_pkg::CH_PAD;
		endcase
	endtask

	task automatic draft_noise();
		draft.delete();
		repeat ($urandom_range(0, 9)) begin
			case ($urandom_range(0, 3))
				0, 1:    draft = {draft, base64_char(6'($urandom))};
				2:       draft = {draft, b64d_pkg::CH_PAD};
				default: draft = {draft, 8'($urandom_range(0, 255))};
			endcase
		end
	endtask

	task automatic build_stimulus();
		int pick;
		draft.delete();
		queue_draft();
		draft = {b64d_pkg::CH_PLUS, b64d_pkg::CH_SLASH, 8'("0"), 8'("9")};
		queue_draft();
		draft = {8'("A"), 8'("z"), b64d_pkg::CH_PAD, b64d_pkg::CH_PAD};
		queue_draft();
		draft = {8'("a"), 8'("z"), 8'("9"), b64d_pkg::CH_PAD};
		queue_draft();
		// stray padding outranks a bad character
		draft = {b64d_pkg::CH_PAD, 8'hFF, 8'("A"), 8'("A")};
		queue_draft();
		// bad length outranks a bad character
		draft = {8'h00};
		queue_draft();
		while (text_stream.size() < ITEM_TARGET) begin
			pick = $urandom_range(0, 9);
			if (pick < 8) begin
				draft_encoded(($urandom_range(0, 7) == 0) ? $urandom_range(8, 24)
					: $urandom_range(0, 7));
				if (pick >= 6)
					corrupt_draft();
			end else begin
				draft_noise();
			end
			queue_draft();
		end
	endtask

	// sender
	text_item_t tx_item;
	int         tx_gap;
	logic       tx_burst;
	logic       hold_flag;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind     <= b64d_pkg::KIND_CHAR;
			symbol   <= 8'h00;
			tx_gap   = 0;
			tx_burst = 1'b0;
		end else begin
			if (in_valid && in_ready)
				decode_char(kind, symbol);
			if (!in_valid || in_ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (text_stream.size() > 0) begin
					tx_item  = text_stream.pop_front();
					in_valid <= 1'b1;
					kind     <= tx_item.kind;
					symbol   <= tx_item.symbol;
					if ($urandom_range(0, 29) == 0)
						tx_burst = !tx_burst;
					// keep pushing while the receiver is held off
					tx_gap = (tx_burst || hold_flag) ? 0 : $urandom_range(0, MAX_GAP);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	decoded_t want;
	int       rx_wait;
	int       hold_left;
	logic     rx_burst;

	task automatic check_result();
		if (decoded_due.size() == 0) begin
			failures++;
			if (failures <= REPORT_MAX)
				$display("unexpected result: status_item=%0b byte=%02h status=%0d last=%0b",
					is_status, data_byte, status, last_of_run);
			return;
		end
		want = decoded_due.pop_front();
		if (is_status !== want.is_status || data_byte !== want.data_byte
				|| status !== want.status || last_of_run !== want.last_of_run) begin
			failures++;
			if (failures <= REPORT_MAX)
				$display("mismatch at result %0d: expected %0b/%02h/%0d/%0b got %0b/%02h/%0d/%0b",
					results_seen, want.is_status, want.data_byte, want.status,
					want.last_of_run, is_status, data_byte, status, last_of_run);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_flag <= 1'b0;
			rx_wait   = 0;
			hold_left = 0;
			rx_burst  = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				check_result();
				results_seen++;
				if ($urandom_range(0, 29) == 0)
					rx_burst = !rx_burst;
				rx_wait = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
				if (results_seen == HOLD_AT_FIRST || results_seen == HOLD_AT_SECOND) begin
					hold_left = HOLD_CYCLES;
					holds_done++;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
			hold_flag <= (hold_left > 0);
		end
	end

	// watchdog on cycles without any transaction
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		clear_decoder();
		build_stimulus();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (text_stream.size() != 0 || in_valid || decoded_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d strings, %0d characters, %0d data bytes, %0d receiver hold-offs",
			strings_done, chars_done, bytes_due, holds_done);
		$display("end status ok/length/padding/character: %0d/%0d/%0d/%0d, %0d failures",
			status_hist[0], status_hist[1], status_hist[2], status_hist[3], failures);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
